// ===== rtl/lbb_pkg.sv =====
// Package for the line break brick generator: request/result payload types,
// cell control/compare structs, and shared constants. No dependencies.
`timescale 1ns / 1ps

package lbb_pkg;

  localparam int unsigned FieldPriceBits = 32;
  localparam int unsigned IndexBits      = 24;
  localparam int unsigned WindowBits     = 5;
  localparam int unsigned DefMaxLines    = 16;
  localparam int unsigned DefPriceBits   = 32;

  localparam logic [WindowBits-1:0] WindowReset = WindowBits'(3);
  localparam logic [IndexBits-1:0]  IndexMax    = {IndexBits{1'b1}};

  typedef struct packed {
    logic signed [FieldPriceBits-1:0] close_price;
    logic                             series_start;
  } lbb_req_t;

  typedef struct packed {
    logic        [IndexBits-1:0]      brick_index;
    logic signed [FieldPriceBits-1:0] brick_open;
    logic signed [FieldPriceBits-1:0] brick_close;
    logic                             brick_up;
  } lbb_rsp_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic shift;   // load neighbor end (or the close at the head)
    logic in_win;  // this cell takes part in the compare
  } cell_ctl_t;

  // Per-cell compare result; both high when the cell is outside the window.
  typedef struct packed {
    logic above;   // close strictly above this end
    logic below;   // close strictly below this end
  } cell_cmp_t;

endpackage

// ===== rtl/line_break_brick_generator.sv =====
// Top level of the line break brick generator: chain of lbb_cell instances
// plus fill/index/seed control and the output register. Uses lbb_pkg.
`timescale 1ns / 1ps

// Line break (three-line-break style) brick generator. Each request carries
// one close price. A close flagged series_start, or the first close after
// reset, seeds the history and produces no result. Every later close is
// compared at once against the newest min(window_lines, MAX_LINES, ends held)
// brick ends: strictly above all of them gives an up brick, strictly below
// all of them a down brick, anything else produces nothing and changes no
// state. A window of zero turns every close into an up brick. Brick ends
// live in a chain of MAX_LINES cells, newest at the head; a new brick shifts
// the chain by one, so the oldest end falls off the tail. The compare across
// all cells and the min/max verdict are formed in the cycle of acceptance,
// and a request is taken whenever the output register is empty or being
// drained, so one close per clock is sustained. window_lines is to be
// written through the cfg port only while idle; the block does not enforce
// this. Its reset value is 3. brick_index counts from 0 per series and
// saturates at its all-ones value.
module line_break_brick_generator #(
  parameter int unsigned MAX_LINES  = lbb_pkg::DefMaxLines,
  parameter int unsigned PRICE_BITS = lbb_pkg::DefPriceBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // close request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lbb_pkg::lbb_req_t                   in_req_i,
  // brick result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lbb_pkg::lbb_rsp_t                   out_rsp_o,
  // window_lines write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lbb_pkg::WindowBits-1:0]      cfg_data_i
);
  import lbb_pkg::*;

  localparam int unsigned FillBits = $clog2(MAX_LINES + 1);

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  logic [WindowBits-1:0] window_q;
  logic [FillBits-1:0]   fill_q, fill_d;     // ends held in the chain
  logic [IndexBits-1:0]  index_q, index_d;   // index of the next brick
  logic                  seeded_q;
  logic                  out_valid_q;
  lbb_rsp_t              out_rsp_q, out_rsp_d;

  logic in_fire, seed, brick, up, down;

  // Close at the internal price width (sign extended or truncated).
  logic signed [PRICE_BITS-1:0] close;
  assign close = PRICE_BITS'(in_req_i.close_price);

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Cell chain: cell 0 holds the newest end
  // ---------------------------------------------------------------------
  logic signed [PRICE_BITS-1:0] cell_end [MAX_LINES];
  cell_ctl_t                    cell_ctl [MAX_LINES];
  logic [MAX_LINES-1:0]         above_v, below_v;

  for (genvar g = 0; g < MAX_LINES; g++) begin : g_cell
    cell_cmp_t cmp;

    // In window when younger than both the configured window and the fill.
    assign cell_ctl[g].in_win = (32'(window_q) > g) && (32'(fill_q) > g);
    assign cell_ctl[g].shift  = seed || brick;

    if (g == 0) begin : g_head
      lbb_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (cell_ctl[g]),
        .close_i    (close),
        .prev_end_i (close),
        .end_o      (cell_end[g]),
        .cmp_o      (cmp)
      );
    end else begin : g_body
      lbb_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (cell_ctl[g]),
        .close_i    (close),
        .prev_end_i (cell_end[g-1]),
        .end_o      (cell_end[g]),
        .cmp_o      (cmp)
      );
    end

    assign above_v[g] = cmp.above;
    assign below_v[g] = cmp.below;
  end

  // Verdict; an empty window leaves every above flag high -> up brick.
  assign seed  = in_fire && (!seeded_q || in_req_i.series_start);
  assign up    = &above_v;
  assign down  = !up && (&below_v);
  assign brick = in_fire && !seed && (up || down);

  // ---------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------
  always_comb begin
    fill_d  = fill_q;
    index_d = index_q;
    if (seed) begin
      fill_d  = FillBits'(1);
      index_d = '0;
    end else if (brick) begin
      if (32'(fill_q) < MAX_LINES) begin
        fill_d = fill_q + FillBits'(1);
      end
      if (index_q != IndexMax) begin
        index_d = index_q + IndexBits'(1);
      end
    end
  end

  always_comb begin
    out_rsp_d.brick_index = index_q;
    out_rsp_d.brick_open  = FieldPriceBits'(cell_end[0]);
    out_rsp_d.brick_close = FieldPriceBits'(close);
    out_rsp_d.brick_up    = up;
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WindowReset;
      fill_q      <= '0;
      index_q     <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        window_q <= cfg_data_i;
      end
      fill_q  <= fill_d;
      index_q <= index_d;
      if (seed) begin
        seeded_q <= 1'b1;
      end
      if (brick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded only on a new brick.
  always_ff @(posedge clk_i) begin
    if (brick) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== rtl/lbb_cell.sv =====
// One cell of the brick-end chain: holds a single end, compares it with the
// incoming close, and passes its end to the next cell on a shift. Uses lbb_pkg.
`timescale 1ns / 1ps

module lbb_cell #(
  parameter int unsigned PRICE_BITS = lbb_pkg::DefPriceBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lbb_pkg::cell_ctl_t            ctl_i,
  input  logic signed [PRICE_BITS-1:0]  close_i,
  input  logic signed [PRICE_BITS-1:0]  prev_end_i,
  output logic signed [PRICE_BITS-1:0]  end_o,
  output lbb_pkg::cell_cmp_t            cmp_o
);
  import lbb_pkg::*;

  logic signed [PRICE_BITS-1:0] end_q;

  // End is only read once written in the current series; cleared on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q <= '0;
    end else if (ctl_i.shift) begin
      end_q <= prev_end_i;
    end
  end

  assign end_o       = end_q;
  assign cmp_o.above = !ctl_i.in_win || (close_i > end_q);
  assign cmp_o.below = !ctl_i.in_win || (close_i < end_q);

endmodule

// ===== dv/lbb_brick_checker.sv =====
// Scoreboard for the line break brick generator: tracks window writes and
// accepted close requests, predicts bricks and checks the result channel.
// Depends on lbb_pkg.
`timescale 1ns / 1ps

module lbb_brick_checker #(
  parameter int unsigned MAX_LINES = lbb_pkg::DefMaxLines
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  lbb_pkg::lbb_req_t              in_req_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  lbb_pkg::lbb_rsp_t              out_rsp_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [lbb_pkg::WindowBits-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import lbb_pkg::*;

  // Brick ends, newest at index 0.
  logic signed [FieldPriceBits-1:0] brick_ends [MAX_LINES];
  int unsigned                      ends_held;
  logic [IndexBits-1:0]             next_index;
  logic                             series_open;
  logic [WindowBits-1:0]            window_lines;
  lbb_rsp_t                         expected_bricks [$];
  int                               fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string what, input longint want, input longint got);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic predict_brick(input lbb_req_t req);
    logic signed [FieldPriceBits-1:0] close_px;
    int unsigned                      span;
    logic                             above_all;
    logic                             below_all;
    lbb_rsp_t                         brick;
    close_px = req.close_price;
    if (!series_open || req.series_start) begin
      brick_ends[0] = close_px;
      ends_held     = 1;
      next_index    = '0;
      series_open   = 1'b1;
      return;
    end
    span = (window_lines > MAX_LINES) ? MAX_LINES : window_lines;
    if (span > ends_held) span = ends_held;
    above_all = 1'b1;
    below_all = 1'b1;
    for (int k = 0; k < span; k++) begin
      if (!(close_px > brick_ends[k])) above_all = 1'b0;
      if (!(close_px < brick_ends[k])) below_all = 1'b0;
    end
    // empty window: above_all wins, so every close is an up brick
    if (!above_all && !below_all) return;
    brick.brick_index = next_index;
    brick.brick_open  = brick_ends[0];
    brick.brick_close = close_px;
    brick.brick_up    = above_all;
    expected_bricks = {expected_bricks, brick};
    if (next_index != IndexMax) next_index++;
    for (int k = MAX_LINES - 1; k > 0; k--) brick_ends[k] = brick_ends[k-1];
    brick_ends[0] = close_px;
    if (ends_held < MAX_LINES) ends_held++;
  endtask

  task automatic check_brick(input lbb_rsp_t got);
    lbb_rsp_t want;
    if (expected_bricks.size() == 0) begin
      report_mismatch("unexpected brick, index", longint'(-1), longint'(got.brick_index));
      return;
    end
    want = expected_bricks.pop_front();
    if (got.brick_index != want.brick_index)
      report_mismatch("brick_index", longint'(want.brick_index), longint'(got.brick_index));
    if (got.brick_open != want.brick_open)
      report_mismatch("brick_open", longint'($signed(want.brick_open)),
                      longint'($signed(got.brick_open)));
    if (got.brick_close != want.brick_close)
      report_mismatch("brick_close", longint'($signed(want.brick_close)),
                      longint'($signed(got.brick_close)));
    if (got.brick_up != want.brick_up)
      report_mismatch("brick_up", longint'(want.brick_up), longint'(got.brick_up));
  endtask

  // Results are registered, so a result taken at an edge is always older
  // than a request taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ends_held    = 0;
      next_index   = '0;
      series_open  = 1'b0;
      window_lines = WindowReset;
      expected_bricks.delete();
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_brick(out_rsp_i);
      if (cfg_valid_i && cfg_ready_i) window_lines = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_brick(in_req_i);
      pending_o = expected_bricks.size();
    end
  end

endmodule

// ===== dv/tb_line_break_brick_generator.sv =====
// Testbench top for the line break brick generator: clock, reset, close
// request and window write stimulus, result-side back pressure and verdict.
// Depends on lbb_pkg, line_break_brick_generator and lbb_brick_checker.
`timescale 1ns / 1ps

module tb_line_break_brick_generator;
  import lbb_pkg::*;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  lbb_req_t              in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  lbb_rsp_t              out_rsp_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [WindowBits-1:0] cfg_data_i  = '0;

  int          fail_count;
  int          bricks_pending;
  // Percent of cycles in which the close sender / brick receiver hold off.
  int unsigned tx_idle_pct = 15;
  int unsigned rx_idle_pct = 53;

  line_break_brick_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  lbb_brick_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_i    (out_rsp_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (bricks_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver back pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAIL line_break_brick_generator");
    $finish;
  end

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Offer one close request and return right after the edge that takes it.
  // Ready is sampled at the falling edge: it only moves on rising edges, so
  // that value holds at the next rising edge.
  task automatic put_close(input logic [FieldPriceBits-1:0] px, input logic start);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_req_i.close_price  <= px;
    in_req_i.series_start <= start;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Stop sending and wait until every expected brick has come out.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (bricks_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Window write; only called after settle().
  task automatic write_window(input logic [WindowBits-1:0] lines);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lines;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
  endtask

  // Hand-picked closes, run with the reset window of 3.
  task automatic directed_closes();
    put_close(32'd0, 1'b0);            // first close after reset seeds without the flag
    put_close(32'd100, 1'b0);          // up
    put_close(32'd100, 1'b0);          // equal to the max: nothing
    put_close(32'd50, 1'b0);           // between the extremes: nothing
    put_close(32'd0, 1'b0);            // equal to the min: nothing
    put_close(-32'sd1, 1'b0);          // down
    put_close(32'h7FFF_FFFF, 1'b0);    // most positive close, up
    put_close(32'h8000_0000, 1'b0);    // most negative close, down
    put_close(32'h8000_0000, 1'b0);    // equal again: nothing
    put_close(-32'sd5, 1'b1);          // flagged series start
    put_close(-32'sd5, 1'b1);          // back-to-back series start
    put_close(-32'sd4, 1'b0);          // index restarts at 0
    put_close(-32'sd3, 1'b0);
    put_close(-32'sd2, 1'b0);
    put_close(-32'sd6, 1'b0);          // down past the three-end window
    put_close(32'h5555_5555, 1'b1);
    put_close(32'hAAAA_AAAA, 1'b0);    // alternating bit patterns
    put_close(32'h7FFF_FFFF, 1'b0);
    put_close(32'h0000_0000, 1'b0);
    put_close(32'hFFFF_FFFF, 1'b0);
  endtask

  // Mostly well-formed series (seed, then a trending walk with pullbacks),
  // plus some fully random closes with random series flags.
  task automatic random_series(input int unsigned items);
    int unsigned                      left;
    int unsigned                      run_len;
    int unsigned                      stride;
    logic                             rising;
    logic                             step_up;
    logic signed [FieldPriceBits-1:0] px;
    left = items;
    while (left > 0) begin
      if ($urandom_range(99) < 10) begin
        put_close($urandom, ($urandom_range(9) == 0));
        left--;
      end else begin
        run_len = $urandom_range(8, 60);
        case ($urandom_range(3))
          0: stride = 4;
          1: stride = 1000;
          2: stride = 1 << 20;
          default: stride = 1 << 30;
        endcase
        if ($urandom_range(1)) px = $urandom;
        else px = $signed(FieldPriceBits'($urandom_range(2000))) - 1000;
        rising = 1'($urandom_range(1));
        put_close(px, 1'b1);
        left--;
        for (int i = 1; i < run_len && left > 0; i++) begin
          if ($urandom_range(99) < 20) rising = ~rising;
          step_up = rising ^ ($urandom_range(99) < 25);  // occasional pullback
          if (step_up) px = px + $urandom_range(stride);
          else px = px - $urandom_range(stride);
          put_close(px, 1'b0);
          left--;
          // now and then let the block drain completely
          if ($urandom_range(119) == 0) settle();
        end
      end
    end
  endtask

  initial begin
    logic [WindowBits-1:0] phase_window [6];
    phase_window = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd7, 5'd2};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(15, 53);
    directed_closes();

    // Two phases per idling regime; window 31 checks clamping to the store.
    for (int p = 0; p < 6; p++) begin
      settle();
      write_window(phase_window[p]);
      if (p < 2) set_idling(15, 53);
      else if (p < 4) set_idling(53, 15);
      else set_idling(0, 0);
      random_series(220);
    end
    settle();

    if (fail_count == 0) begin
      $display("PASS line_break_brick_generator");
    end else begin
      $display("FAIL line_break_brick_generator");
    end
    $finish;
  end

endmodule
